// ===== rtl/b2da_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none
package b2da_pkg;

   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 6;
   localparam int BCD_W   = 4;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [BCD_W-1:0]   digit_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dabble_stat_type;

endpackage
`default_nettype wire

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level: unsigned 64-bit binary to decimal ASCII digit stream.
//
// Input channel req_*: one word carries a 64-bit unsigned value.
// Output channel rsp_*: one word per decimal digit, most significant first,
// ASCII '0'..'9' in rsp_tdata[5:0]; rsp_tlast marks the final digit.
// Leading zeros are dropped; zero gives the single digit '0'. With
// MAX_DIGITS below 20 only the low MAX_DIGITS decimal digits are kept.
// One value is converted at a time. After acceptance the double dabble
// shift register takes in one input bit per cycle, the BCD digits are
// then handed to the emitter, and the emitter steps through all
// MAX_DIGITS digit positions in turn: leading zeros are shifted past
// without output. req_tready returns once the last digit sits in the
// output register.
// A stall on rsp_tready holds the output register and stops the emitter
// at its next digit word.
// Reset clears all control state: no word pending, req_tready high.
`default_nettype none
module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = 20
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [b2da_pkg::REQ_TDATA_W-1:0]      req_tdata,   // [63:0] value
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [b2da_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                                  rsp_tlast    // last_digit
);
   import b2da_pkg::*;

   localparam int BcdW = BCD_W * MAX_DIGITS;

   logic              req_accept;
   logic [BcdW-1:0]   bcd;
   dabble_stat_type   stat;
   logic              emit_busy;
   char_type          digit_char;

   assign req_tready = !stat.busy && !stat.done && !emit_busy;
   assign req_accept = req_tvalid && req_tready;

   b2da_dabble #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .value (req_tdata[VALUE_W-1:0]),
      .bcd   (bcd),
      .stat  (stat)
   );

   b2da_emit #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (stat.done),
      .bcd        (bcd),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .digit_char (digit_char),
      .last_digit (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_TDATA_W - CHAR_W)'(0), digit_char};

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stat.busy)
      else $error("converter not busy after accepting a word");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(stat.busy && emit_busy))
      else $error("dabble and emitter active together");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
      else $error("digit character out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/b2da_dabble.sv =====
// Bit-serial double dabble: shifts the binary word into a BCD register one bit per cycle.
`default_nettype none
module b2da_dabble #(
   parameter int MAX_DIGITS = 20
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  b2da_pkg::value_type        value,
   output logic [4*MAX_DIGITS-1:0]          bcd,
   output b2da_pkg::dabble_stat_type        stat
);
   import b2da_pkg::*;

   localparam int BcdW = BCD_W * MAX_DIGITS;
   localparam int CntW = $clog2(VALUE_W);

   value_type         sh_ff, sh_in;
   logic [BcdW-1:0]   bcd_ff, bcd_in;
   logic [BcdW-1:0]   adj;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              last_step;

   always_comb begin
      digit_type d;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         d = bcd_ff[i*BCD_W +: BCD_W];
         if (d inside {[4'd5:4'd15]}) begin
            adj[i*BCD_W +: BCD_W] = d + 4'd3;
         end else begin
            adj[i*BCD_W +: BCD_W] = d;
         end
      end
   end

   assign last_step = busy_ff && (cnt_ff == CntW'(VALUE_W - 1));

   always_comb begin
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = last_step;
      if (start) begin
         sh_in   = value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = sh_ff << 1;
         bcd_in = {adj[BcdW-2:0], sh_ff[VALUE_W-1]};
         cnt_in = cnt_ff + CntW'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign bcd       = bcd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/b2da_emit.sv =====
// Digit emitter: shifts BCD digits out most significant first, drops leading zeros.
`default_nettype none
module b2da_emit #(
   parameter int MAX_DIGITS = 20
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        load,
   input  wire  [4*MAX_DIGITS-1:0]    bcd,
   output logic                       busy,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output b2da_pkg::char_type         digit_char,
   output logic                       last_digit
);
   import b2da_pkg::*;

   localparam int BcdW = BCD_W * MAX_DIGITS;
   localparam int CntW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [BcdW-1:0]   bcd_ff, bcd_in;
   logic [CntW-1:0]   pos_ff, pos_in;
   logic              seen_ff, seen_in;
   logic              active_ff, active_in;
   logic              valid_ff, valid_in;
   char_type          char_ff, char_in;
   logic              last_ff, last_in;

   digit_type         top_digit;
   logic              is_last, skip, slot_free, step, send;

   assign top_digit = bcd_ff[BcdW-1 -: BCD_W];
   assign is_last   = pos_ff == CntW'(MAX_DIGITS - 1);
   assign skip      = (top_digit == 4'd0) && !seen_ff && !is_last;
   assign slot_free = !valid_ff || rsp_tready;
   assign step      = active_ff && (skip || slot_free);
   assign send      = active_ff && !skip && slot_free;

   always_comb begin
      bcd_in    = bcd_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      active_in = active_ff;
      valid_in  = valid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (load) begin
         bcd_in    = bcd;
         pos_in    = '0;
         seen_in   = 1'b0;
         active_in = 1'b1;
      end else if (step) begin
         bcd_in    = bcd_ff << BCD_W;
         pos_in    = pos_ff + CntW'(1);
         seen_in   = seen_ff || send;
         active_in = !is_last;
      end
      if (send) begin
         valid_in = 1'b1;
         char_in  = ASCII_ZERO + CHAR_W'(top_digit);
         last_in  = is_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         pos_ff    <= '0;
         seen_ff   <= 1'b0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign busy       = active_ff;
   assign rsp_tvalid = valid_ff;
   assign digit_char = char_ff;
   assign last_digit = last_ff;

endmodule
`default_nettype wire
